@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/tlpf_pkg.sv @@
// Constants and codes shared by the priority FIFO and its checker.
`default_nettype none
package tlpf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int NUM_LEVELS  = 3;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH   = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);

    // Priority levels
    localparam logic [1:0] LVL_LOW    = 2'd0;
    localparam logic [1:0] LVL_NORMAL = 2'd1;
    localparam logic [1:0] LVL_HIGH   = 2'd2;

    // Operation codes
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // Fault codes
    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_DEQ_EMPTY = 2'd1;
    localparam logic [1:0] FAULT_ENQ_FULL  = 2'd2;

endpackage
`default_nettype wire

@@ design/three_level_priority_fifo.sv @@
// Strict-priority queue engine: three FIFO queues sharing one entry memory.
// The result register is loaded in ST_DONE, after ST_READ, for each accepted command.
// A new command is taken only in ST_IDLE, after the write / read-back / load sequence
// on the single shared entry memory; a stalled result holds the block in ST_DONE.
// Reset (rst_n, async low) clears pointers, occupancy, state and output valid;
// the entry memory is not cleared, only entries counted by occupancy reach the result.
`default_nettype none
module three_level_priority_fifo
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [2:0]  s_axis_tuser,   // [0] mode, [2:1] level
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] head_value
    output logic [5:0]       m_axis_tuser    // [0] head_valid, [2:1] head_level,
                                             // [3] all_empty, [5:4] fault
);

    // Sequencer: accept/update, read head entry, load result register.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int PTR_W  = tlpf_pkg::PTR_W;
    localparam int OCC_W  = tlpf_pkg::OCC_W;
    localparam int ADDR_W = tlpf_pkg::ADDR_W;
    localparam int DW     = tlpf_pkg::DATA_WIDTH;

    // Entry memory: queue q occupies entries q*QUEUE_DEPTH .. q*QUEUE_DEPTH+QUEUE_DEPTH-1.
    logic [DW-1:0] queue_mem [tlpf_pkg::MEM_DEPTH];

    logic [1:0]       state_reg, state_next;
    logic [PTR_W-1:0] rd_ptr_reg [tlpf_pkg::NUM_LEVELS];
    logic [PTR_W-1:0] rd_ptr_next [tlpf_pkg::NUM_LEVELS];
    logic [PTR_W-1:0] wr_ptr_reg [tlpf_pkg::NUM_LEVELS];
    logic [PTR_W-1:0] wr_ptr_next [tlpf_pkg::NUM_LEVELS];
    logic [OCC_W-1:0] occ_reg [tlpf_pkg::NUM_LEVELS];
    logic [OCC_W-1:0] occ_next [tlpf_pkg::NUM_LEVELS];
    logic [1:0]       fault_reg, fault_next;
    logic [DW-1:0]    rd_data_reg;

    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_data_reg, out_data_next;
    logic [5:0]       out_user_reg, out_user_next;

    logic             cmd_mode;
    logic [1:0]       cmd_level;
    logic [1:0]       enq_q;
    logic [1:0]       top_q;
    logic             any_busy;
    logic             accept;
    logic             out_free;
    logic             mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(tlpf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [1:0] q,
                                                     input logic [PTR_W-1:0] p);
        entry_addr = ADDR_W'(q) * ADDR_W'(tlpf_pkg::QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

    assign cmd_mode  = s_axis_tuser[0];
    assign cmd_level = s_axis_tuser[2:1];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Level code 3 falls into the low queue.
    always_comb
    begin
        case (cmd_level)
            tlpf_pkg::LVL_HIGH:   enq_q = tlpf_pkg::LVL_HIGH;
            tlpf_pkg::LVL_NORMAL: enq_q = tlpf_pkg::LVL_NORMAL;
            default:              enq_q = tlpf_pkg::LVL_LOW;
        endcase
    end

    // Highest non-empty queue from current occupancy.
    always_comb
    begin
        any_busy = 1'b1;
        if (occ_reg[tlpf_pkg::LVL_HIGH] != '0)
            top_q = tlpf_pkg::LVL_HIGH;
        else if (occ_reg[tlpf_pkg::LVL_NORMAL] != '0)
            top_q = tlpf_pkg::LVL_NORMAL;
        else
        begin
            top_q    = tlpf_pkg::LVL_LOW;
            any_busy = (occ_reg[tlpf_pkg::LVL_LOW] != '0);
        end
    end

    assign wr_addr = entry_addr(enq_q, wr_ptr_reg[enq_q]);
    assign rd_addr = entry_addr(top_q, rd_ptr_reg[top_q]);

    // Command update
    always_comb
    begin
        state_next = state_reg;
        fault_next = fault_reg;
        mem_we     = 1'b0;
        for (int i = 0; i < tlpf_pkg::NUM_LEVELS; i++)
        begin
            rd_ptr_next[i] = rd_ptr_reg[i];
            wr_ptr_next[i] = wr_ptr_reg[i];
            occ_next[i]    = occ_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                    fault_next = tlpf_pkg::FAULT_NONE;
                    if (cmd_mode == tlpf_pkg::MODE_ENQ)
                    begin
                        if (occ_reg[enq_q] == OCC_W'(tlpf_pkg::QUEUE_DEPTH))
                            fault_next = tlpf_pkg::FAULT_ENQ_FULL;
                        else
                        begin
                            mem_we             = 1'b1;
                            wr_ptr_next[enq_q] = bump(wr_ptr_reg[enq_q]);
                            occ_next[enq_q]    = occ_reg[enq_q] + OCC_W'(1);
                        end
                    end
                    else
                    begin
                        if (!any_busy)
                            fault_next = tlpf_pkg::FAULT_DEQ_EMPTY;
                        else
                        begin
                            rd_ptr_next[top_q] = bump(rd_ptr_reg[top_q]);
                            occ_next[top_q]    = occ_reg[top_q] - OCC_W'(1);
                        end
                    end
                end
            end
            ST_READ:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Result register: loaded in ST_DONE from the head entry read in ST_READ.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (state_reg == ST_DONE && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = any_busy ? 32'(rd_data_reg) : '0;
            out_user_next  = {fault_reg, !any_busy, top_q, any_busy};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fault_reg     <= tlpf_pkg::FAULT_NONE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < tlpf_pkg::NUM_LEVELS; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                occ_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < tlpf_pkg::NUM_LEVELS; i++)
            begin
                rd_ptr_reg[i] <= rd_ptr_next[i];
                wr_ptr_reg[i] <= wr_ptr_next[i];
                occ_reg[i]    <= occ_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    // Entry memory write port (enqueue) and registered read port (head fetch).
    always_ff @(posedge clk)
    begin
        if (mem_we)
            queue_mem[wr_addr] <= DW'(s_axis_tdata);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            rd_data_reg <= queue_mem[rd_addr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
`default_nettype wire

@@ design/tlpf_checker.sv @@
// Port-level checker for the priority FIFO, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module tlpf_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [31:0] s_axis_tdata,
    input wire logic [2:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [5:0]  m_axis_tuser
);

    logic unused_in;
    assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ (^s_axis_tuser);

    // Head is valid exactly when some queue is non-empty.
    `ASSERT_IMPL(a_valid_vs_empty, m_axis_tvalid, m_axis_tuser[0] == !m_axis_tuser[3])

    // Empty result carries zero value and level.
    `ASSERT_IMPL(a_empty_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 32'd0 && m_axis_tuser[2:1] == tlpf_pkg::LVL_LOW)

    // A dequeue that faulted on empty leaves every queue empty.
    `ASSERT_IMPL(a_deq_empty, m_axis_tvalid && m_axis_tuser[5:4] == tlpf_pkg::FAULT_DEQ_EMPTY, m_axis_tuser[3])

    // Stalled result holds.
    `ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind three_level_priority_fifo tlpf_checker u_tlpf_checker (.*);
`default_nettype wire

@@ sim/tb.sv @@
// Stream testbench for the three-level strict-priority FIFO with a scoreboard.
`timescale 1ns / 100ps

module tb;

    localparam int CMD_TARGET  = 1700;      // rough total size of the command list
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 250;       // result count that starts the long stall
    localparam int HOLD_CYCLES = 160;
    localparam int PAUSE_AT    = 900;       // sender drains the block before this command
    localparam int SETTLE      = 20;

    // One command as the block takes it
    typedef struct packed {
        logic                            mode;
        logic [1:0]                      level;
        logic [tlpf_pkg::DATA_WIDTH-1:0] value;
    } cmd_t;

    // One head report as the block gives it
    typedef struct packed {
        logic [1:0]                      fault;
        logic                            all_empty;
        logic [1:0]                      head_level;
        logic                            head_valid;
        logic [tlpf_pkg::DATA_WIDTH-1:0] head_value;
    } head_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;   // [31:0] value
    logic [2:0]            s_axis_tuser = '0;   // [0] mode, [2:1] level
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;        // [31:0] head_value
    logic [5:0]            m_axis_tuser;        // [0] head_valid, [2:1] head_level,
                                                // [3] all_empty, [5:4] fault

    three_level_priority_fifo u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow queues: entries indexed from the oldest one at rd_idx
    logic [tlpf_pkg::DATA_WIDTH-1:0] entries [tlpf_pkg::NUM_LEVELS][tlpf_pkg::QUEUE_DEPTH];
    int                    rd_idx [tlpf_pkg::NUM_LEVELS] = '{0, 0, 0};
    int                    fill   [tlpf_pkg::NUM_LEVELS] = '{0, 0, 0};

    cmd_t         cmd_backlog[$];
    head_report_t head_reports_due[$];
    int           total_cmds = 0;
    int           sent_count = 0;
    int           recv_count = 0;
    int           fail_count = 0;
    int           hold_left  = 0;
    int           cycle_count = 0;

    // Highest non-empty level, -1 when all queues are empty
    function automatic int busiest_level();
        int lv;
        for (lv = tlpf_pkg::NUM_LEVELS - 1; lv >= 0; lv--)
            if (fill[lv] != 0)
                return lv;
        return -1;
    endfunction

    // Apply one command to the shadow queues and return the report it causes
    function automatic head_report_t priority_queue_step(cmd_t c);
        head_report_t r;
        logic [1:0]   q;
        int           top;
        r = '0;
        r.fault = tlpf_pkg::FAULT_NONE;
        if (c.mode == tlpf_pkg::MODE_ENQ)
        begin
            // any code other than high or normal lands in the low queue
            q = (c.level == tlpf_pkg::LVL_HIGH) ? tlpf_pkg::LVL_HIGH :
                (c.level == tlpf_pkg::LVL_NORMAL) ? tlpf_pkg::LVL_NORMAL : tlpf_pkg::LVL_LOW;
            if (fill[q] >= tlpf_pkg::QUEUE_DEPTH)
                r.fault = tlpf_pkg::FAULT_ENQ_FULL;
            else
            begin
                entries[q][(rd_idx[q] + fill[q]) % tlpf_pkg::QUEUE_DEPTH] = c.value;
                fill[q]++;
            end
        end
        else
        begin
            top = busiest_level();
            if (top < 0)
                r.fault = tlpf_pkg::FAULT_DEQ_EMPTY;
            else
            begin
                rd_idx[top] = (rd_idx[top] + 1) % tlpf_pkg::QUEUE_DEPTH;
                fill[top]--;
            end
        end
        top = busiest_level();
        if (top < 0)
            r.all_empty = 1'b1;
        else
        begin
            r.head_valid = 1'b1;
            r.head_level = top[1:0];
            r.head_value = entries[top][rd_idx[top]];
        end
        return r;
    endfunction

    // Idle percentages: sender-light first, then receiver-light, then none
    function automatic int sender_idle_pct();
        if (sent_count < 600)
            return 14;
        if (sent_count < 1200)
            return 60;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (sent_count < 600)
            return 60;
        if (sent_count < 1200)
            return 14;
        return 0;
    endfunction

    task automatic queue_cmd(logic mode, logic [1:0] level,
                             logic [tlpf_pkg::DATA_WIDTH-1:0] value);
        cmd_t c;
        c.mode  = mode;
        c.level = level;
        c.value = value;
        cmd_backlog.push_back(c);
    endtask

    function automatic logic [tlpf_pkg::DATA_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_level();
        int r;
        r = $urandom_range(9);
        if (r < 3)
            return tlpf_pkg::LVL_HIGH;
        if (r < 6)
            return tlpf_pkg::LVL_NORMAL;
        if (r < 9)
            return tlpf_pkg::LVL_LOW;
        return 2'd3;
    endfunction

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Command driver: predicts at each accepted transfer, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin : drive
            cmd_t taken;
            cmd_t nxt;
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken.mode  = s_axis_tuser[0];
                taken.level = s_axis_tuser[2:1];
                taken.value = s_axis_tdata;
                head_reports_due.push_back(priority_queue_step(taken));
                sent_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (cmd_backlog.size() == 0
                    || (sent_count == PAUSE_AT && head_reports_due.size() != 0)
                    || $urandom_range(99) < sender_idle_pct())
                    s_axis_tvalid <= 1'b0;
                else
                begin
                    nxt = cmd_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.value;
                    s_axis_tuser  <= {nxt.level, nxt.mode};
                end
            end
        end
    end

    // Result monitor and scoreboard
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin : watch
            head_report_t want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                recv_count++;
                if (head_reports_due.size() == 0)
                begin
                    $error("result transfer with no command pending: tdata=%h tuser=%h",
                           m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    want = head_reports_due.pop_front();
                    if (m_axis_tdata !== want.head_value)
                    begin
                        $error("head_value: expected %h, got %h", want.head_value, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== want.head_valid)
                    begin
                        $error("head_valid: expected %b, got %b", want.head_valid,
                               m_axis_tuser[0]);
                        fail_count++;
                    end
                    if (m_axis_tuser[2:1] !== want.head_level)
                    begin
                        $error("head_level: expected %0d, got %0d", want.head_level,
                               m_axis_tuser[2:1]);
                        fail_count++;
                    end
                    if (m_axis_tuser[3] !== want.all_empty)
                    begin
                        $error("all_empty: expected %b, got %b", want.all_empty,
                               m_axis_tuser[3]);
                        fail_count++;
                    end
                    if (m_axis_tuser[5:4] !== want.fault)
                    begin
                        $error("fault: expected %0d, got %0d", want.fault, m_axis_tuser[5:4]);
                        fail_count++;
                    end
                end
                // long back-pressure so the block backs up into its input
                if (recv_count == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    initial
    begin : stimulus
        int i;
        int len;
        int enq_pct;

        // directed: empty dequeue, overfill of high, every level, code 3, extremes
        queue_cmd(tlpf_pkg::MODE_DEQ, tlpf_pkg::LVL_HIGH, '1);
        for (i = 0; i < tlpf_pkg::QUEUE_DEPTH + 1; i++)
            queue_cmd(tlpf_pkg::MODE_ENQ, tlpf_pkg::LVL_HIGH,
                      (i == 0) ? '0 : (i == 1) ? '1 : $urandom);
        queue_cmd(tlpf_pkg::MODE_ENQ, tlpf_pkg::LVL_NORMAL, 32'h8000_0001);
        queue_cmd(tlpf_pkg::MODE_ENQ, tlpf_pkg::LVL_LOW, '0);
        queue_cmd(tlpf_pkg::MODE_ENQ, 2'd3, '1);
        queue_cmd(tlpf_pkg::MODE_DEQ, 2'd3, 32'h5A5A_A5A5);
        queue_cmd(tlpf_pkg::MODE_DEQ, tlpf_pkg::LVL_LOW, '0);

        // random bursts, each leaning toward filling, draining or neither
        while (cmd_backlog.size() < CMD_TARGET)
        begin
            len = $urandom_range(80, 20);
            case ($urandom_range(2))
                0:       enq_pct = 85;
                1:       enq_pct = 50;
                default: enq_pct = 15;
            endcase
            for (i = 0; i < len; i++)
                queue_cmd(($urandom_range(99) < enq_pct) ? tlpf_pkg::MODE_ENQ
                                                         : tlpf_pkg::MODE_DEQ,
                          pick_level(), pick_value());
        end
        total_cmds = cmd_backlog.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count < total_cmds || head_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/tlpf_pkg.sv
design/three_level_priority_fifo.sv
design/tlpf_checker.sv
sim/tb.sv
